// ===== hdl/mf3_pkg.sv =====
// Shared constants, types and compare functions of the 3x3 median filter.
package mf3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int EW_W      = ADDR_W + 1;
    localparam int NCH       = 3;
    localparam int PIX_W     = 8;
    localparam int IMG_W_W   = 11;
    localparam int IMG_H_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MIN_DIM   = 3;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = IMG_W_W'(640);
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = IMG_H_W'(480);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [2:0]       trio_t;
    typedef pix_t [NCH-1:0]   pix_vec_t;
    typedef trio_t [NCH-1:0]  col_t;

    typedef struct packed {
        pix_vec_t upper;
        pix_vec_t middle;
    } line_pair_t;

    typedef struct packed {
        logic emit;
        logic frame_end;
    } tag_t;

    function automatic pix_t min2(pix_t a, pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t max2(pix_t a, pix_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic pix_t min3(pix_t a, pix_t b, pix_t c);
        return min2(min2(a, b), c);
    endfunction

    function automatic pix_t max3(pix_t a, pix_t b, pix_t c);
        return max2(max2(a, b), c);
    endfunction

    function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // Element 0 is the smallest, element 2 the largest.
    function automatic trio_t sort3(trio_t v);
        pix_t a;
        pix_t b;
        pix_t c;
        pix_t t;
        a = v[0];
        b = v[1];
        c = v[2];
        if (a > b) begin
            t = a; a = b; b = t;
        end
        if (b > c) begin
            t = b; b = c; c = t;
        end
        if (a > b) begin
            t = a; a = b; b = t;
        end
        return {c, b, a};
    endfunction

endpackage

// ===== hdl/mf3_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/mf3_median.sv =====
// Window of sorted columns and the three-stage median-of-nine pipeline.
module mf3_median
    import mf3_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  col_t     in_col,
    input  tag_t     in_tag,
    output logic     out_valid,
    input  logic     out_ready,
    output pix_vec_t out_med,
    output logic     out_frame_end
);

    col_t [2:0]  win_reg;
    logic        v2_reg;
    logic        v2_next;
    tag_t        tag2_reg;
    trio_t [NCH-1:0] red_reg;
    trio_t [NCH-1:0] red_next;
    logic        v3_reg;
    logic        v3_next;
    tag_t        tag3_reg;
    pix_vec_t    med_reg;
    pix_vec_t    med_next;
    logic        fe_reg;
    logic        ov_reg;
    logic        ov_next;
    logic        rdy2;
    logic        rdy3;
    col_t        sorted_col;

    assign rdy3     = !ov_reg || out_ready;
    assign rdy2     = !v3_reg || rdy3;
    assign in_ready = !v2_reg || rdy2;

    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            sorted_col[ch] = sort3(in_col[ch]);
            red_next[ch][0] = max3(win_reg[0][ch][0], win_reg[1][ch][0], win_reg[2][ch][0]);
            red_next[ch][1] = med3(win_reg[0][ch][1], win_reg[1][ch][1], win_reg[2][ch][1]);
            red_next[ch][2] = min3(win_reg[0][ch][2], win_reg[1][ch][2], win_reg[2][ch][2]);
            med_next[ch]    = med3(red_reg[ch][0], red_reg[ch][1], red_reg[ch][2]);
        end
    end

    always_comb begin
        v2_next = v2_reg;
        if (rdy2) begin
            v2_next = 1'b0;
        end
        if (in_valid && in_ready) begin
            v2_next = 1'b1;
        end
        v3_next = v3_reg;
        if (rdy3) begin
            v3_next = 1'b0;
        end
        if (v2_reg && rdy2) begin
            v3_next = 1'b1;
        end
        ov_next = ov_reg;
        if (out_ready) begin
            ov_next = 1'b0;
        end
        if (v3_reg && rdy3 && tag3_reg.emit) begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            win_reg  <= {sorted_col, win_reg[2], win_reg[1]};
            tag2_reg <= in_tag;
        end
        if (v2_reg && rdy2) begin
            red_reg  <= red_next;
            tag3_reg <= tag2_reg;
        end
        if (v3_reg && rdy3 && tag3_reg.emit) begin
            med_reg <= med_next;
            fe_reg  <= tag3_reg.frame_end;
        end
    end

    assign out_valid     = ov_reg;
    assign out_med       = med_reg;
    assign out_frame_end = fe_reg;

endmodule

// ===== hdl/median_filter_3x3_core.sv =====
// Top level of the streaming 3x3 median filter for three-channel 8-bit pixels.
//
//   channel   direction  handshake             payload
//   s_        in         s_valid / s_ready     s_pixel_ch0..2
//   m_        out        m_valid / m_ready     m_median_ch0..2, m_frame_end
//   cfg_      in         cfg_wr_en             cfg_index, cfg_wdata
//
// One pixel per clock unless m_ stalls; medians follow the input, window and reduction
// registers. Line RAM is read once per pixel at its column and written back from pix1_reg.
// Reset clears counters and valid flags and loads width 640, height 480; RAM is not cleared.
// A stalled m_ side fills the internal stages before s_ready drops.
module median_filter_3x3_core
    import mf3_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PIX_W-1:0]     s_pixel_ch0,
    input  logic [PIX_W-1:0]     s_pixel_ch1,
    input  logic [PIX_W-1:0]     s_pixel_ch2,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PIX_W-1:0]     m_median_ch0,
    output logic [PIX_W-1:0]     m_median_ch1,
    output logic [PIX_W-1:0]     m_median_ch2,
    output logic                 m_frame_end,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic [IMG_W_W-1:0] image_width_reg;
    logic [IMG_H_W-1:0] image_height_reg;
    logic [ADDR_W-1:0]  col_reg;
    logic [ADDR_W-1:0]  col_next;
    logic [IMG_H_W-1:0] row_reg;
    logic [IMG_H_W-1:0] row_next;
    logic [EW_W-1:0]    eff_w;
    logic [IMG_H_W-1:0] eff_h;
    logic [EW_W-1:0]    col_inc;
    logic [IMG_H_W:0]   row_inc;
    logic               col_wrap;
    logic               row_wrap;
    logic               accept;
    logic               v1_reg;
    logic               v1_next;
    pix_vec_t           pix1_reg;
    logic [ADDR_W-1:0]  addr1_reg;
    tag_t               tag1_reg;
    tag_t               tag0;
    line_pair_t         rd_line;
    line_pair_t         wr_line;
    logic [$bits(line_pair_t)-1:0] rd_bits;
    logic               med_in_ready;
    col_t               col1;
    pix_vec_t           med;

    always_comb begin
        if (image_width_reg < IMG_W_W'(MIN_DIM)) begin
            eff_w = EW_W'(MIN_DIM);
        end else if (32'(image_width_reg) > MAX_WIDTH) begin
            eff_w = EW_W'(MAX_WIDTH);
        end else begin
            eff_w = EW_W'(image_width_reg);
        end
        eff_h = (image_height_reg < IMG_H_W'(MIN_DIM)) ? IMG_H_W'(MIN_DIM) : image_height_reg;
    end

    assign col_inc  = {1'b0, col_reg} + EW_W'(1);
    assign row_inc  = {1'b0, row_reg} + (IMG_H_W + 1)'(1);
    assign col_wrap = col_inc >= eff_w;
    assign row_wrap = row_inc >= {1'b0, eff_h};

    assign tag0.emit      = (row_reg >= IMG_H_W'(2)) && (col_reg >= ADDR_W'(2));
    assign tag0.frame_end = col_wrap && row_wrap;

    assign s_ready = !v1_reg || med_in_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_wrap) begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_inc[IMG_H_W-1:0];
            end else begin
                col_next = col_inc[ADDR_W-1:0];
            end
        end
        v1_next = v1_reg;
        if (med_in_ready) begin
            v1_next = 1'b0;
        end
        if (accept) begin
            v1_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
            col_reg          <= '0;
            row_reg          <= '0;
            v1_reg           <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH: begin
                        image_width_reg <= cfg_wdata[IMG_W_W-1:0];
                    end
                    REG_IMAGE_HEIGHT: begin
                        image_height_reg <= cfg_wdata[IMG_H_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            col_reg <= col_next;
            row_reg <= row_next;
            v1_reg  <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix1_reg  <= {s_pixel_ch2, s_pixel_ch1, s_pixel_ch0};
            addr1_reg <= col_reg;
            tag1_reg  <= tag0;
        end
    end

    assign rd_line        = line_pair_t'(rd_bits);
    assign wr_line.upper  = rd_line.middle;
    assign wr_line.middle = pix1_reg;

    mf3_ram #(
        .WIDTH ($bits(line_pair_t)),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (v1_reg && med_in_ready),
        .waddr (addr1_reg),
        .wdata (wr_line),
        .re    (accept),
        .raddr (col_reg),
        .rdata (rd_bits)
    );

    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            col1[ch][0] = rd_line.upper[ch];
            col1[ch][1] = rd_line.middle[ch];
            col1[ch][2] = pix1_reg[ch];
        end
    end

    mf3_median u_median (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (v1_reg),
        .in_ready      (med_in_ready),
        .in_col        (col1),
        .in_tag        (tag1_reg),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .out_med       (med),
        .out_frame_end (m_frame_end)
    );

    assign m_median_ch0 = med[0];
    assign m_median_ch1 = med[1];
    assign m_median_ch2 = med[2];

endmodule

// ===== bench/tb_median_filter_3x3_core.sv =====
// Self-checking testbench for the streaming 3x3 median filter core.
`timescale 1ns / 1ps

module tb_median_filter_3x3_core
    import mf3_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 250;

    typedef struct {
        pix_vec_t med;
        logic     frame_end;
    } median_t;

    class median_predictor;
        pix_vec_t         line_up[MAX_WIDTH];
        pix_vec_t         line_mid[MAX_WIDTH];
        col_t             win[2];
        int               col_cnt;
        int               row_cnt;
        logic [IMG_W_W-1:0] width_reg;
        logic [IMG_H_W-1:0] height_reg;
        median_t          medians_due[$];
        int               errors;
        int               pixels;
        int               medians;
        int               frames;
        int               reg_writes;

        function new();
            foreach (line_up[i]) begin
                line_up[i] = '0;
                line_mid[i] = '0;
            end
            win[0] = '0;
            win[1] = '0;
            col_cnt = 0;
            row_cnt = 0;
            width_reg = IMAGE_WIDTH_RST;
            height_reg = IMAGE_HEIGHT_RST;
            errors = 0;
            pixels = 0;
            medians = 0;
            frames = 0;
            reg_writes = 0;
        endfunction

        function int eff_width();
            int w;
            w = width_reg;
            if (w < MIN_DIM) w = MIN_DIM;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            return w;
        endfunction

        function int eff_height();
            return (height_reg < MIN_DIM) ? MIN_DIM : int'(height_reg);
        endfunction

        function bit at_frame_start();
            return col_cnt == 0 && row_cnt == 0;
        endfunction

        function int pending();
            return medians_due.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            reg_writes++;
            if (idx == REG_IMAGE_WIDTH)
                width_reg = data[IMG_W_W-1:0];
            else if (idx == REG_IMAGE_HEIGHT)
                height_reg = data[IMG_H_W-1:0];
        endfunction

        function pix_t median9(pix_t v[9]);
            int lt;
            int le;
            for (int i = 0; i < 9; i++) begin
                lt = 0;
                le = 0;
                for (int j = 0; j < 9; j++) begin
                    if (v[j] < v[i]) lt++;
                    if (v[j] <= v[i]) le++;
                end
                if (lt <= 4 && le >= 5) return v[i];
            end
            return '0;
        endfunction

        function void note_pixel(pix_vec_t px);
            int w;
            int h;
            int c;
            col_t cur;
            median_t r;
            bit col_wrap;
            bit row_wrap;
            pix_t nine[9];
            w = eff_width();
            h = eff_height();
            c = (col_cnt < MAX_WIDTH) ? col_cnt : MAX_WIDTH - 1;
            for (int ch = 0; ch < NCH; ch++) begin
                cur[ch][0] = line_up[c][ch];
                cur[ch][1] = line_mid[c][ch];
                cur[ch][2] = px[ch];
            end
            col_wrap = (col_cnt + 1 >= w);
            row_wrap = (row_cnt + 1 >= h);
            if (row_cnt >= 2 && col_cnt >= 2) begin
                for (int ch = 0; ch < NCH; ch++) begin
                    for (int k = 0; k < 3; k++) begin
                        nine[k*3]   = win[0][ch][k];
                        nine[k*3+1] = win[1][ch][k];
                        nine[k*3+2] = cur[ch][k];
                    end
                    r.med[ch] = median9(nine);
                end
                r.frame_end = col_wrap && row_wrap;
                medians_due.push_back(r);
            end
            for (int ch = 0; ch < NCH; ch++) begin
                line_up[c][ch] = cur[ch][1];
                line_mid[c][ch] = cur[ch][2];
            end
            win[0] = win[1];
            win[1] = cur;
            if (col_wrap) begin
                col_cnt = 0;
                row_cnt = row_wrap ? 0 : row_cnt + 1;
            end else begin
                col_cnt++;
            end
            pixels++;
        endfunction

        function void check_median(pix_vec_t med, logic frame_end);
            median_t e;
            if (medians_due.size() == 0) begin
                $error("median with no request pending: %0h %0h %0h frame_end %0b",
                       med[0], med[1], med[2], frame_end);
                errors++;
                return;
            end
            e = medians_due.pop_front();
            medians++;
            if (frame_end === 1'b1) frames++;
            for (int ch = 0; ch < NCH; ch++) begin
                if (med[ch] !== e.med[ch]) begin
                    $error("median_ch%0d expected %0d got %0d", ch, e.med[ch], med[ch]);
                    errors++;
                end
            end
            if (frame_end !== e.frame_end) begin
                $error("frame_end expected %0b got %0b", e.frame_end, frame_end);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_pixel_ch0 = '0;
    logic [PIX_W-1:0]     s_pixel_ch1 = '0;
    logic [PIX_W-1:0]     s_pixel_ch2 = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [PIX_W-1:0]     m_median_ch0;
    logic [PIX_W-1:0]     m_median_ch1;
    logic [PIX_W-1:0]     m_median_ch2;
    logic                 m_frame_end;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    median_predictor pred;
    bit idle_on = 1'b1;
    int stall_left = 0;
    int quiet = 0;

    median_filter_3x3_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_ch0  (s_pixel_ch0),
        .s_pixel_ch1  (s_pixel_ch1),
        .s_pixel_ch2  (s_pixel_ch2),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_median_ch0 (m_median_ch0),
        .m_median_ch1 (m_median_ch1),
        .m_median_ch2 (m_median_ch2),
        .m_frame_end  (m_frame_end),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (idle_on && aresetn && $urandom_range(0, 4) == 0) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            pred.check_median({m_median_ch2, m_median_ch1, m_median_ch0}, m_frame_end);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
                quiet = 0;
            else
                quiet = quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic pix_vec_t random_pixel();
        pix_vec_t px;
        for (int ch = 0; ch < NCH; ch++) begin
            case ($urandom_range(0, 5))
                0: px[ch] = 8'h00;
                1: px[ch] = 8'hFF;
                2: px[ch] = PIX_W'($urandom_range(120, 123));
                default: px[ch] = PIX_W'($urandom);
            endcase
        end
        return px;
    endfunction

    task automatic push_pixel(input pix_vec_t px);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel_ch0 <= px[0];
        s_pixel_ch1 <= px[1];
        s_pixel_ch2 <= px[2];
        do @(posedge aclk); while (!s_ready);
        pred.note_pixel(px);
        @(negedge aclk);
    endtask

    task automatic push_to_frame_end();
        do push_pixel(random_pixel()); while (!pred.at_frame_start());
    endtask

    // Drain all pending medians, then let the pipeline go quiet.
    task automatic settle();
        s_valid <= 1'b0;
        while (pred.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                             input bit more);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        pred.write_reg(idx, data);
        @(negedge aclk);
        if (!more) cfg_wr_en <= 1'b0;
    endtask

    initial begin
        pix_vec_t px;
        int base;
        int w;
        int n;
        logic [CFG_W-1:0] wdata;
        pred = new();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // smallest frame, out-of-range geometry, write to unused index
        cfg_write(REG_IMAGE_WIDTH, CFG_W'(2), 1'b1);
        cfg_write(REG_IMAGE_HEIGHT, CFG_W'(1), 1'b1);
        cfg_write(REG_SPARE, '1, 1'b0);
        for (int k = 0; k < 9; k++)
            push_pixel({(k % 2) ? 8'hAA : 8'h55, 8'hFF, 8'h00});
        for (int k = 0; k < 9; k++) begin
            px[0] = PIX_W'(k * 29 + 3);
            px[1] = ~px[0];
            px[2] = (k < 5) ? 8'h80 : 8'h7F;
            push_pixel(px);
        end

        // saturated width over a full row, then narrowed and cut short mid-row
        settle();
        cfg_write(REG_IMAGE_WIDTH, CFG_W'(16'h07FF), 1'b1);
        cfg_write(REG_IMAGE_HEIGHT, CFG_W'(16'hFFFF), 1'b0);
        repeat (MAX_WIDTH + 40) push_pixel(random_pixel());
        settle();
        cfg_write(REG_IMAGE_WIDTH, CFG_W'(8), 1'b1);
        cfg_write(REG_IMAGE_HEIGHT, CFG_W'(2), 1'b0);
        push_to_frame_end();
        settle();
        cfg_write(REG_IMAGE_WIDTH, CFG_W'(MAX_WIDTH), 1'b0);

        base = pred.pixels;
        while (pred.pixels - base < RANDOM_ITEMS) begin
            settle();
            case ($urandom_range(0, 9))
                0: w = $urandom_range(0, 2);
                1: w = $urandom_range(13, 40);
                default: w = $urandom_range(3, 12);
            endcase
            wdata = CFG_W'(w);
            if ($urandom_range(0, 3) == 0)
                wdata = wdata | (CFG_W'($urandom_range(0, 31)) << IMG_W_W);
            cfg_write(REG_IMAGE_WIDTH, wdata, 1'b1);
            if ($urandom_range(0, 5) == 0)
                cfg_write(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 2)), 1'b0);
            else
                cfg_write(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(3, 8)), 1'b0);
            repeat ($urandom_range(1, 2)) begin
                if (pred.pixels - base > RANDOM_ITEMS - 100) idle_on = 1'b0;
                if ($urandom_range(0, 3) == 0) begin
                    n = $urandom_range(1, pred.eff_width() * pred.eff_height() - 1);
                    for (int i = 0; i < n; i++) begin
                        push_pixel(random_pixel());
                        if (pred.at_frame_start()) break;
                    end
                    if (!pred.at_frame_start()) begin
                        settle();
                        if ($urandom_range(0, 1))
                            cfg_write(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 10)), 1'b0);
                        else
                            cfg_write(REG_IMAGE_WIDTH,
                                      CFG_W'($urandom_range(0, pred.eff_width())), 1'b0);
                        push_to_frame_end();
                    end
                end else begin
                    push_to_frame_end();
                end
            end
        end

        s_valid <= 1'b0;
        while (pred.pending() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        $display("run: %0d pixels sent, %0d medians checked, %0d frame ends, %0d reg writes",
                 pred.pixels, pred.medians, pred.frames, pred.reg_writes);
        $display("geometry from 3x3 up to 1024 wide, resizes inside frames, stalls both sides");
        if (pred.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mf3_pkg.sv
hdl/mf3_ram.sv
hdl/mf3_median.sv
hdl/median_filter_3x3_core.sv
bench/tb_median_filter_3x3_core.sv
